// ===== src/card_id_code_store_assert.svh =====
// ----------------------------------------------------------------------------
// card_id_code_store_assert.svh
// Assertion macros shared by the card id code store RTL.
// ----------------------------------------------------------------------------
`ifndef CARD_ID_CODE_STORE_ASSERT_SVH
`define CARD_ID_CODE_STORE_ASSERT_SVH

// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define CICS_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("card_id_code_store: same-cycle check failed");

// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define CICS_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("card_id_code_store: next-cycle check failed");

`endif

// ===== src/cics_pkg.sv =====
// ----------------------------------------------------------------------------
// cics_pkg
// Widths, codes and key helpers for the card id code store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cics_pkg;

  localparam int KEY_BYTES = 12;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 4;
  localparam int SLOT_W    = 5;

  localparam logic FUNC_SAVE = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // lengths above the key size act as the full key
  function automatic len_t clamp_len(input len_t len);
    len_t res;
    res = (len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len;
    return res;
  endfunction

  // one byte of ones for each leading key byte that takes part
  function automatic key_t byte_mask(input len_t len);
    key_t m;
    m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== src/cics_if.sv =====
// ----------------------------------------------------------------------------
// cics_if
// Valid/ready channels for requests and responses of the code store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cics_in_if;
  import cics_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  logic  [63:0] key_low;
  logic  [31:0] key_high;
  len_t  key_len;
  code_t code_in;

  modport source (output valid, func, key_low, key_high, key_len, code_in,
                  input ready);
  modport sink   (input valid, func, key_low, key_high, key_len, code_in,
                  output ready);
endinterface

interface cics_out_if;
  import cics_pkg::*;

  logic  valid;
  logic  ready;
  logic  status;
  code_t code_out;
  slot_t slot;

  modport source (output valid, status, code_out, slot, input ready);
  modport sink   (input valid, status, code_out, slot, output ready);
endinterface

// ===== src/cics_match.sv =====
// ----------------------------------------------------------------------------
// cics_match
// Shared key comparator: masked compare of one stored key per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cics_match (
  input  cics_pkg::key_t stored_key,
  input  cics_pkg::key_t req_key,
  input  cics_pkg::len_t key_len,
  output cics_pkg::key_t key_mask,
  output logic           hit
);
  import cics_pkg::*;

  assign key_mask = byte_mask(key_len);
  // zero length masks everything, so it always hits
  assign hit      = ((stored_key ^ req_key) & key_mask) == '0;

endmodule

// ===== src/card_id_code_store.sv =====
// ----------------------------------------------------------------------------
// card_id_code_store
// Keyed table of card ids (up to 12 bytes) with a 32-bit code per slot.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request transactions (func, key_low, key_high, key_len, code_in).
//            func 0 saves key and code, func 1 loads the code for a key.
//   out_ch : one response transaction per request (status, code_out, slot).
//   Slots are searched lowest first with one comparator; the first slot whose
//   leading key_len bytes match is taken. A save with no match appends at the
//   next free slot or reports full (status 1).
// Timing:
//   One request at a time. in_ch.ready is high only while idle. A request is
//   scanned from slot 0; the key/code memory read port feeds the comparator
//   one slot per cycle until the hit slot or the last slot is compared, then
//   the write-back state and the response state follow. A new request is
//   taken only after the response has been accepted.
// Reset:
//   Synchronous, active low. The slot count and the code flag of the next
//   free slot are cleared; memory contents beyond the slot count read as zero,
//   so no clearing pass is needed and requests are taken right after reset.
// Stall:
//   The response holds in its output register until out_ch.ready; no new
//   request is taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "card_id_code_store_assert.svh"

module card_id_code_store #(
  parameter int SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cics_in_if.sink    in_ch,
  cics_out_if.source out_ch
);
  import cics_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot address
  localparam int UW = $clog2(SLOTS + 1);                  // slot count
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  // key and code memories, one read and one write port
  key_t  key_mem  [SLOTS];
  code_t code_mem [SLOTS];

  logic [1:0]    state_r, state_nxt;

  // latched request
  logic          req_func_r;
  key_t          req_key_r;
  len_t          req_len_r;
  code_t         req_code_r;

  // scan pointer: iss = address being read, cmp = address being compared
  logic [AW-1:0] iss_r, iss_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0] cmp_addr_r, cmp_addr_nxt;
  key_t          rd_key_r;
  code_t         rd_code_r;
  logic          rd_en;

  // slot count, and whether the code of the next free slot was written
  logic [UW-1:0] used_count_r, used_count_nxt;
  logic          code_wr_r, code_wr_nxt;

  // write-back
  logic          wr_act_r, wr_act_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  key_t          wr_key_r, wr_key_nxt;
  code_t         wr_code_r, wr_code_nxt;

  // response
  logic          res_status_r, res_status_nxt;
  code_t         res_code_r, res_code_nxt;
  slot_t         res_slot_r, res_slot_nxt;

  logic          stored_live, code_live;
  key_t          eff_key;
  code_t         eff_code;
  key_t          key_mask;
  logic          hit;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = (state_r == ST_RESP);
  assign out_ch.status   = res_status_r;
  assign out_ch.code_out = res_code_r;
  assign out_ch.slot     = res_slot_r;

  // Slots at or above the count read as a zero key. The code of the slot at the
  // count is live only once a save has hit it there.
  assign stored_live = UW'(cmp_addr_r) < used_count_r;
  assign code_live   = stored_live || ((UW'(cmp_addr_r) == used_count_r) && code_wr_r);
  assign eff_key     = stored_live ? rd_key_r : '0;
  assign eff_code    = code_live ? rd_code_r : '0;

  cics_match u_match (
    .stored_key (eff_key),
    .req_key    (req_key_r),
    .key_len    (req_len_r),
    .key_mask   (key_mask),
    .hit        (hit)
  );

  // stop reading once the hit slot is on the compare stage, so its data holds
  assign rd_en = (state_r == ST_SCAN) && !iss_done_r && !(cmp_vld_r && hit);

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    iss_done_nxt   = iss_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_addr_nxt   = cmp_addr_r;
    used_count_nxt = used_count_r;
    code_wr_nxt    = code_wr_r;
    wr_act_nxt     = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    wr_key_nxt     = wr_key_r;
    wr_code_nxt    = wr_code_r;
    res_status_nxt = res_status_r;
    res_code_nxt   = res_code_r;
    res_slot_nxt   = res_slot_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt    = ST_SCAN;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cmp_vld_nxt  = 1'b1;
          cmp_addr_nxt = iss_r;
          iss_nxt      = iss_r + AW'(1);
          iss_done_nxt = (iss_r == LAST);
        end
        if (cmp_vld_r && (hit || (cmp_addr_r == LAST))) begin
          state_nxt      = ST_WRITE;
          res_status_nxt = STAT_OK;
          res_code_nxt   = '0;
          res_slot_nxt   = SLOT_W'(cmp_addr_r);
          if (req_func_r == FUNC_SAVE) begin
            if (hit) begin
              // overwrite leading bytes, keep the rest of the stored key
              wr_act_nxt  = 1'b1;
              wr_addr_nxt = cmp_addr_r;
              wr_key_nxt  = (req_key_r & key_mask) | (eff_key & ~key_mask);
              wr_code_nxt = req_code_r;
              if (!stored_live) begin
                code_wr_nxt = 1'b1;
              end
            end else if (used_count_r >= UW'(SLOTS)) begin
              res_status_nxt = STAT_FAIL;
              res_slot_nxt   = '0;
            end else begin
              // append, zero padded
              wr_act_nxt     = 1'b1;
              wr_addr_nxt    = AW'(used_count_r);
              wr_key_nxt     = req_key_r & key_mask;
              wr_code_nxt    = req_code_r;
              used_count_nxt = used_count_r + UW'(1);
              code_wr_nxt    = 1'b0;
              res_slot_nxt   = SLOT_W'(used_count_r);
            end
          end else begin
            if (hit) begin
              res_code_nxt = eff_code;
            end else begin
              res_status_nxt = STAT_FAIL;
              res_slot_nxt   = '0;
            end
          end
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_vld_r    <= 1'b0;
      wr_act_r     <= 1'b0;
      used_count_r <= '0;
      code_wr_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      wr_act_r     <= wr_act_nxt;
      used_count_r <= used_count_nxt;
      code_wr_r    <= code_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    iss_done_r   <= iss_done_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_key_r     <= wr_key_nxt;
    wr_code_r    <= wr_code_nxt;
    res_status_r <= res_status_nxt;
    res_code_r   <= res_code_nxt;
    res_slot_r   <= res_slot_nxt;
    if (in_ch.valid && in_ch.ready) begin
      req_func_r <= in_ch.func;
      req_key_r  <= {in_ch.key_high, in_ch.key_low};
      req_len_r  <= clamp_len(in_ch.key_len);
      req_code_r <= in_ch.code_in;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r  <= key_mem[iss_r];
      rd_code_r <= code_mem[iss_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_act_r) begin
      key_mem[wr_addr_r]  <= wr_key_r;
      code_mem[wr_addr_r] <= wr_code_r;
    end
  end

  // checks
  `CICS_AST_NOW(a_used_bound, 1'b1, used_count_r <= UW'(SLOTS))
  `CICS_AST_NEXT(a_used_only_scan, state_r != ST_SCAN, used_count_r == $past(used_count_r))
  `CICS_AST_NOW(a_fail_zero, out_ch.valid && res_status_r == STAT_FAIL, {res_slot_r, res_code_r} == '0)
  `CICS_AST_NOW(a_save_no_code, (state_r == ST_RESP) && (req_func_r == FUNC_SAVE), res_code_r == '0)
  `CICS_AST_NOW(a_cmp_in_scan, cmp_vld_r, state_r == ST_SCAN)
  `CICS_AST_NOW(a_wr_in_write, wr_act_r, state_r == ST_WRITE)

endmodule
